### rtl/weighted_moving_average_filter_assert.svh
// Assertion macros shared by the weighted moving average filter RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef WEIGHTED_MOVING_AVERAGE_FILTER_ASSERT_SVH
`define WEIGHTED_MOVING_AVERAGE_FILTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WMA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("wma assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define WMA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("wma assertion failed");

`endif

### rtl/wma_pkg.sv
// Package for the weighted moving average filter: state type, register
// indexes and the tap weight selection. Depends on nothing.
`timescale 1ns / 1ps

package wma_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TAPS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTS_0_3   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTS_4_7   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTS_8_11  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTS_12_15 = 3'd4;

    localparam logic [4:0]  TAPS_RESET    = 5'd16;
    localparam logic [63:0] WEIGHTS_RESET = 64'h0001_0001_0001_0001;

    typedef logic [3:0][63:0] t_weight_regs;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DIV,
        ST_RESULT
    } t_wma_state;

    // Taps past the sixteenth have no weight register and weigh zero.
    function automatic logic [15:0] tap_weight(input t_weight_regs regs,
                                               input logic [5:0] idx);
        logic [15:0] w;
        begin
            w = '0;
            if (idx < 6'd16) begin
                w = regs[idx[3:2]][{idx[1:0], 4'b0000} +: 16];
            end
            return w;
        end
    endfunction

endpackage

### rtl/wma_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module wma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/weighted_moving_average_filter.sv
// Weighted moving average filter: top level with sequencer, MAC and divider.
// Depends on wma_pkg, wma_ram and weighted_moving_average_filter_assert.svh.
// Usage:
// - Input channel (i_in_valid / o_in_stall) carries one 16-bit sample per
//   transaction. Output channel (o_out_valid / i_out_stall) carries one result
//   per input transaction: filtered value, window-full and divide-by-zero flags.
// - The configuration port writes window_taps (index 0) and the four weight
//   registers (indexes 1 to 4). Writing window_taps empties the window.
// - While the window is filling, a sample is written to the sample RAM at once
//   and its zero result passes through the result state into the output
//   register; the sequencer then returns to idle for the next sample.
// - With a full window, one RAM read per tap feeds a registered multiplier and
//   accumulator, then a radix-2 divider forms the quotient. The result moves
//   through the result state into the output register, and the sequencer then
//   returns to idle for the next sample. A zero weight sum skips the divider.
// - One sample is processed at a time; o_in_stall is high while it is in work.
// - A finished result sits in the output register while the receiver stalls;
//   the next sample is still accepted and processed, and waits for the output
//   register to free before its result is loaded.
// - Reset clears the window and restores window_taps to 16 and all weights to 1.
`timescale 1ns / 1ps
`include "weighted_moving_average_filter_assert.svh"

module weighted_moving_average_filter #(
    parameter int MAX_TAPS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [15:0]                    i_sample_in,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [15:0]                    o_filtered_value,
    output logic                           o_window_full,
    output logic                           o_divide_by_zero,
    input  logic                           i_cfg_wr_en,
    input  logic [wma_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [wma_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int IW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int TW = $clog2(MAX_TAPS + 1);

    wma_pkg::t_wma_state   r_state, n_state;
    logic [4:0]            r_taps, n_taps;
    wma_pkg::t_weight_regs r_weights, n_weights;
    logic [IW-1:0]         r_oldest, n_oldest;
    logic [TW-1:0]         r_fill, n_fill;
    logic [15:0]           r_sample, n_sample;
    logic [TW-1:0]         r_rd_idx, n_rd_idx;
    logic [IW-1:0]         r_rd_pos, n_rd_pos;
    logic                  r_v1, n_v1;
    logic [IW-1:0]         r_tap1, n_tap1;
    logic                  r_v2, n_v2;
    logic [31:0]           r_prod, n_prod;
    logic [15:0]           r_w2, n_w2;
    logic [31:0]           r_acc, n_acc;
    logic [15:0]           r_wsum, n_wsum;
    logic [15:0]           r_rem, n_rem;
    logic [31:0]           r_quo, n_quo;
    logic [4:0]            r_div_cnt, n_div_cnt;
    logic [15:0]           r_res_value, n_res_value;
    logic                  r_res_full, n_res_full;
    logic                  r_res_dz, n_res_dz;
    logic                  r_out_valid, n_out_valid;
    logic [15:0]           r_out_value, n_out_value;
    logic                  r_out_full, n_out_full;
    logic                  r_out_dz, n_out_dz;

    logic [TW-1:0]  w_taps;
    logic [TW:0]    w_fill_sum;
    logic [IW-1:0]  w_fill_pos;
    logic [TW-1:0]  w_pos_inc;
    logic [TW-1:0]  w_old_inc;
    logic [15:0]    w_weight;
    logic [16:0]    w_trial;
    logic           w_ge;
    logic           w_issue;
    logic           w_accept;
    logic           w_wr_en;
    logic [IW-1:0]  w_wr_addr;
    logic [15:0]    w_wr_data;
    logic [15:0]    w_rd_data;

    // Effective tap count: zero counts as one, and the store depth caps it.
    always_comb begin
        if (r_taps == 5'd0) begin
            w_taps = TW'(1);
        end else if (32'(r_taps) > MAX_TAPS) begin
            w_taps = TW'(MAX_TAPS);
        end else begin
            w_taps = TW'(r_taps);
        end
    end

    always_comb begin
        w_fill_sum = (TW+1)'(r_oldest) + (TW+1)'(r_fill);
        if (w_fill_sum >= (TW+1)'(w_taps)) begin
            w_fill_sum = w_fill_sum - (TW+1)'(w_taps);
        end
        w_fill_pos = w_fill_sum[IW-1:0];
    end

    assign w_pos_inc = TW'(r_rd_pos) + TW'(1);
    assign w_old_inc = TW'(r_oldest) + TW'(1);
    assign w_weight  = wma_pkg::tap_weight(r_weights, 6'(r_tap1));
    assign w_trial   = {r_rem, r_quo[31]};
    assign w_ge      = (w_trial >= {1'b0, r_wsum});
    assign w_issue   = (r_state == wma_pkg::ST_MAC) && (r_rd_idx != w_taps);

    assign o_in_stall = (r_state != wma_pkg::ST_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;

    wma_ram #(
        .WIDTH (16),
        .DEPTH (MAX_TAPS),
        .AW    (IW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_issue),
        .i_rd_addr (r_rd_pos),
        .o_rd_data (w_rd_data)
    );

    always_comb begin
        n_state     = r_state;
        n_taps      = r_taps;
        n_weights   = r_weights;
        n_oldest    = r_oldest;
        n_fill      = r_fill;
        n_sample    = r_sample;
        n_rd_idx    = r_rd_idx;
        n_rd_pos    = r_rd_pos;
        n_v1        = w_issue;
        n_tap1      = r_rd_idx[IW-1:0];
        n_v2        = r_v1;
        n_prod      = 32'(w_rd_data) * 32'(w_weight);
        n_w2        = w_weight;
        n_acc       = r_acc;
        n_wsum      = r_wsum;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_div_cnt   = r_div_cnt;
        n_res_value = r_res_value;
        n_res_full  = r_res_full;
        n_res_dz    = r_res_dz;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_value = r_out_value;
        n_out_full  = r_out_full;
        n_out_dz    = r_out_dz;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_oldest;
        w_wr_data   = r_sample;

        unique case (r_state)
            wma_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_sample = i_sample_in;
                    if (r_fill == w_taps) begin
                        n_rd_idx = '0;
                        n_rd_pos = r_oldest;
                        n_acc    = '0;
                        n_wsum   = '0;
                        n_state  = wma_pkg::ST_MAC;
                    end else begin
                        w_wr_en     = 1'b1;
                        w_wr_addr   = w_fill_pos;
                        w_wr_data   = i_sample_in;
                        n_fill      = r_fill + TW'(1);
                        n_res_value = '0;
                        n_res_full  = 1'b0;
                        n_res_dz    = 1'b0;
                        n_state     = wma_pkg::ST_RESULT;
                    end
                end
            end
            wma_pkg::ST_MAC: begin
                if (w_issue) begin
                    n_rd_idx = r_rd_idx + TW'(1);
                    n_rd_pos = (w_pos_inc >= w_taps) ? '0 : w_pos_inc[IW-1:0];
                end
                if (r_v2) begin
                    n_acc  = r_acc + r_prod;
                    n_wsum = r_wsum + r_w2;
                end
                // All reads issued and the pipeline drained: replace the oldest.
                if (!w_issue && !r_v1 && !r_v2) begin
                    w_wr_en  = 1'b1;
                    n_oldest = (w_old_inc >= w_taps) ? '0 : w_old_inc[IW-1:0];
                    if (r_wsum == 16'd0) begin
                        n_res_value = '0;
                        n_res_full  = 1'b1;
                        n_res_dz    = 1'b1;
                        n_state     = wma_pkg::ST_RESULT;
                    end else begin
                        n_rem     = '0;
                        n_quo     = r_acc;
                        n_div_cnt = '0;
                        n_state   = wma_pkg::ST_DIV;
                    end
                end
            end
            wma_pkg::ST_DIV: begin
                // Restoring division, one quotient bit per cycle.
                n_rem     = w_ge ? 16'(w_trial - {1'b0, r_wsum}) : w_trial[15:0];
                n_quo     = {r_quo[30:0], w_ge};
                n_div_cnt = r_div_cnt + 5'd1;
                if (r_div_cnt == 5'd31) begin
                    n_res_value = n_quo[15:0];
                    n_res_full  = 1'b1;
                    n_res_dz    = 1'b0;
                    n_state     = wma_pkg::ST_RESULT;
                end
            end
            wma_pkg::ST_RESULT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_value = r_res_value;
                    n_out_full  = r_res_full;
                    n_out_dz    = r_res_dz;
                    n_state     = wma_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = wma_pkg::ST_IDLE;
            end
        endcase

        if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                wma_pkg::CFG_WINDOW_TAPS: begin
                    n_taps   = i_cfg_wdata[4:0];
                    n_oldest = '0;
                    n_fill   = '0;
                end
                wma_pkg::CFG_WEIGHTS_0_3:   n_weights[0] = i_cfg_wdata;
                wma_pkg::CFG_WEIGHTS_4_7:   n_weights[1] = i_cfg_wdata;
                wma_pkg::CFG_WEIGHTS_8_11:  n_weights[2] = i_cfg_wdata;
                wma_pkg::CFG_WEIGHTS_12_15: n_weights[3] = i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wma_pkg::ST_IDLE;
            r_taps      <= wma_pkg::TAPS_RESET;
            r_weights   <= {4{wma_pkg::WEIGHTS_RESET}};
            r_oldest    <= '0;
            r_fill      <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_taps      <= n_taps;
            r_weights   <= n_weights;
            r_oldest    <= n_oldest;
            r_fill      <= n_fill;
            r_v1        <= n_v1;
            r_v2        <= n_v2;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sample    <= n_sample;
        r_rd_idx    <= n_rd_idx;
        r_rd_pos    <= n_rd_pos;
        r_tap1      <= n_tap1;
        r_prod      <= n_prod;
        r_w2        <= n_w2;
        r_acc       <= n_acc;
        r_wsum      <= n_wsum;
        r_rem       <= n_rem;
        r_quo       <= n_quo;
        r_div_cnt   <= n_div_cnt;
        r_res_value <= n_res_value;
        r_res_full  <= n_res_full;
        r_res_dz    <= n_res_dz;
        r_out_value <= n_out_value;
        r_out_full  <= n_out_full;
        r_out_dz    <= n_out_dz;
    end

    assign o_out_valid      = r_out_valid;
    assign o_filtered_value = r_out_value;
    assign o_window_full    = r_out_full;
    assign o_divide_by_zero = r_out_dz;

    `WMA_ASSERT_NOW(a_window_bounds, i_clk, i_rst_n, 1'b1, (r_fill <= w_taps) && (TW'(r_oldest) < w_taps))
    `WMA_ASSERT_NOW(a_fill_result_zero, i_clk, i_rst_n, o_out_valid && !o_window_full, (o_filtered_value == 16'd0) && !o_divide_by_zero)
    `WMA_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, w_accept, r_state != wma_pkg::ST_IDLE)
    `WMA_ASSERT_NOW(a_div_nonzero, i_clk, i_rst_n, r_state == wma_pkg::ST_DIV, r_wsum != 16'd0)

endmodule

### verif/wma_average_checker.sv
// Result checker for the weighted moving average filter. It follows the register
// port, predicts every average and compares it with the output transactions.
// Depends on wma_pkg for the register indexes and reset values.
`timescale 1ns / 1ps

module wma_average_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic [15:0]                    i_sample_in,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic [15:0]                    i_filtered_value,
    input  logic                           i_window_full,
    input  logic                           i_divide_by_zero,
    input  logic                           i_cfg_wr_en,
    input  logic [wma_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [wma_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output int                             o_mismatches,
    output int                             o_averages_owed
);

    localparam int WINDOW_DEPTH = 16;

    typedef struct packed {
        logic [15:0] filtered_value;
        logic        window_full;
        logic        divide_by_zero;
    } t_average;

    logic [4:0]  taps_reg;
    logic [63:0] gain_regs [4];
    logic [15:0] window [WINDOW_DEPTH];
    int unsigned oldest;
    int unsigned filled;
    t_average    averages_due [$];

    initial begin
        o_mismatches    = 0;
        o_averages_owed = 0;
    end

    // A zero count behaves as one tap and anything past the store depth as all of it.
    function automatic int unsigned active_taps();
        int unsigned t;
        t = taps_reg;
        if (t == 0) t = 1;
        if (t > WINDOW_DEPTH) t = WINDOW_DEPTH;
        return t;
    endfunction

    function automatic logic [15:0] tap_gain(input int unsigned k);
        if (k >= 16) return '0;
        return gain_regs[k / 4][16 * (k % 4) +: 16];
    endfunction

    // Averages the window if full (not the new sample), then stores the sample.
    function automatic t_average push_sample(input logic [15:0] sample);
        t_average    avg;
        int unsigned taps;
        int unsigned pos;
        int unsigned k;
        logic [31:0] acc;
        logic [15:0] wsum;
        logic [15:0] gain;
        taps = active_taps();
        avg  = '0;
        if (oldest >= taps) oldest = 0;
        if (filled > taps) filled = 0;
        if (filled == taps) begin
            acc  = '0;
            wsum = '0;
            pos  = oldest;
            for (k = 0; k < taps; k++) begin
                gain = tap_gain(k);
                acc  = acc + {16'b0, window[pos]} * {16'b0, gain};
                wsum = wsum + gain;
                pos  = (pos + 1 >= taps) ? 0 : pos + 1;
            end
            avg.window_full = 1'b1;
            if (wsum == '0) begin
                avg.divide_by_zero = 1'b1;
            end else begin
                avg.filtered_value = 16'(acc / {16'b0, wsum});
            end
            window[oldest] = sample;
            oldest = (oldest + 1 >= taps) ? 0 : oldest + 1;
        end else begin
            pos = oldest + filled;
            if (pos >= taps) pos -= taps;
            window[pos] = sample;
            filled++;
        end
        return avg;
    endfunction

    always @(posedge i_clk) begin
        t_average want;
        if (!i_rst_n) begin
            taps_reg = wma_pkg::TAPS_RESET;
            foreach (gain_regs[r]) gain_regs[r] = wma_pkg::WEIGHTS_RESET;
            oldest = 0;
            filled = 0;
            averages_due.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index) inside
                    wma_pkg::CFG_WINDOW_TAPS: begin
                        taps_reg = i_cfg_wdata[4:0];
                        oldest   = 0;
                        filled   = 0;
                    end
                    wma_pkg::CFG_WEIGHTS_0_3, wma_pkg::CFG_WEIGHTS_4_7,
                    wma_pkg::CFG_WEIGHTS_8_11, wma_pkg::CFG_WEIGHTS_12_15: begin
                        gain_regs[i_cfg_index - wma_pkg::CFG_WEIGHTS_0_3] = i_cfg_wdata;
                    end
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                averages_due.push_back(push_sample(i_sample_in));
            end
            if (i_out_valid && !i_out_stall) begin
                if (averages_due.size() == 0) begin
                    $error("result with no sample outstanding: filtered_value %0d",
                           i_filtered_value);
                    o_mismatches++;
                end else begin
                    want = averages_due.pop_front();
                    if (i_filtered_value !== want.filtered_value) begin
                        $error("filtered_value: expected %0d, actual %0d",
                               want.filtered_value, i_filtered_value);
                        o_mismatches++;
                    end
                    if (i_window_full !== want.window_full) begin
                        $error("window_full: expected %0d, actual %0d",
                               want.window_full, i_window_full);
                        o_mismatches++;
                    end
                    if (i_divide_by_zero !== want.divide_by_zero) begin
                        $error("divide_by_zero: expected %0d, actual %0d",
                               want.divide_by_zero, i_divide_by_zero);
                        o_mismatches++;
                    end
                end
            end
        end
        o_averages_owed = averages_due.size();
    end

endmodule

### verif/tb_weighted_moving_average_filter.sv
// Testbench top for the weighted moving average filter: drives samples,
// register writes and output stalls, and reports the verdict.
// Depends on wma_pkg, weighted_moving_average_filter and wma_average_checker.
`timescale 1ns / 1ps

module tb_weighted_moving_average_filter;

    localparam int CLK_PERIOD_NS = 4;
    localparam int RESET_CYCLES  = 10;
    localparam int RANDOM_ITEMS  = 1700;
    localparam int IDLE_PERCENT  = 31;
    localparam int CALM_FIRST    = 700;
    localparam int CALM_LAST     = 1000;
    localparam int IDLE_LIMIT    = 4000;
    localparam int SETTLE_CYCLES = 60;
    localparam int IDX_W         = wma_pkg::CFG_IDX_W;
    localparam int DATA_W        = wma_pkg::CFG_DATA_W;

    localparam logic [IDX_W-1:0] CFG_SPARE_FIRST = wma_pkg::CFG_WEIGHTS_12_15 + 1'b1;
    localparam logic [IDX_W-1:0] CFG_SPARE_LAST  = '1;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic [15:0]           i_sample_in = '0;
    logic                  i_out_stall = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [IDX_W-1:0]      i_cfg_index = '0;
    logic [DATA_W-1:0]     i_cfg_wdata = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [15:0]           o_filtered_value;
    logic                  o_window_full;
    logic                  o_divide_by_zero;

    bit calm = 1'b0;
    int mismatches;
    int averages_owed;
    int idle_cycles = 0;

    weighted_moving_average_filter dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_sample_in      (i_sample_in),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_filtered_value (o_filtered_value),
        .o_window_full    (o_window_full),
        .o_divide_by_zero (o_divide_by_zero),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata)
    );

    wma_average_checker average_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_sample_in      (i_sample_in),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_filtered_value (o_filtered_value),
        .i_window_full    (o_window_full),
        .i_divide_by_zero (o_divide_by_zero),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_mismatches     (mismatches),
        .o_averages_owed  (averages_owed)
    );

    always #(CLK_PERIOD_NS / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
    end

    // The run is cut off once no transaction has moved on either side for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Holds the input off until every outstanding average has been taken.
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (averages_owed != 0);
        @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [63:0] data);
        drain();
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // The stall is looked at mid-cycle, where it has settled, so that the
    // acceptance decision never races the edge.
    task automatic send(input logic [15:0] sample);
        bit taken;
        while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_sample_in <= sample;
        do begin
            @(negedge i_clk);
            taken = !o_in_stall;
            @(posedge i_clk);
        end while (!taken);
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return 16'($urandom_range(15));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [4:0] pick_taps();
        case ($urandom_range(7))
            0: return 5'd0;
            1: return 5'd1;
            2: return 5'd16;
            3: return 5'd31;
            4: return 5'($urandom_range(31, 17));
            default: return 5'($urandom_range(8, 2));
        endcase
    endfunction

    function automatic logic [63:0] pick_weights();
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(5))
            0: w = '0;
            1: w = '1;
            2: w = wma_pkg::WEIGHTS_RESET;
            3: for (int k = 0; k < 4; k++) w[16 * k +: 16] = 16'($urandom_range(3));
            4: w = w & (64'hFFFF << (16 * $urandom_range(3)));
            default: ;
        endcase
        return w;
    endfunction

    initial begin
        int  seg_len;
        int  random_count;
        bit  fresh;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings, sixteen taps of weight one: all-ones samples fill the
        // window and then give the largest possible average.
        repeat (17) send(16'hFFFF);

        // A zero tap count acts as one tap; with no weight on it the second
        // sample divides by zero.
        write_reg(wma_pkg::CFG_WINDOW_TAPS, 64'd0);
        write_reg(wma_pkg::CFG_WEIGHTS_0_3, 64'd0);
        send(16'h0000);
        send(16'h1234);

        // Two weights that add up to 2^16 wrap to a zero sum, and a write to an
        // unused index must change nothing.
        write_reg(wma_pkg::CFG_WINDOW_TAPS, 64'd2);
        write_reg(wma_pkg::CFG_WEIGHTS_0_3, 64'h0000_0000_0001_FFFF);
        write_reg(CFG_SPARE_FIRST, '1);
        send(16'h0000);
        send(16'hFFFF);
        send(16'h8001);

        random_count = 0;
        fresh        = 1'b1;
        while (random_count < RANDOM_ITEMS) begin
            // Leaving the tap count alone keeps the window running across weight changes.
            if (fresh || $urandom_range(3) != 0) begin
                write_reg(wma_pkg::CFG_WINDOW_TAPS, {$urandom, 27'($urandom), pick_taps()});
            end
            for (int r = 0; r < 4; r++) begin
                if (fresh || $urandom_range(1) != 0) begin
                    write_reg(IDX_W'(wma_pkg::CFG_WEIGHTS_0_3 + r), pick_weights());
                end
            end
            if ($urandom_range(7) == 0) begin
                write_reg(IDX_W'($urandom_range(CFG_SPARE_LAST, CFG_SPARE_FIRST)),
                          {$urandom, $urandom});
            end
            seg_len = $urandom_range(60, 5);
            for (int n = 0; n < seg_len; n++) begin
                calm = (random_count >= CALM_FIRST) && (random_count < CALM_LAST);
                if ((fresh && n == seg_len / 2) || $urandom_range(299) == 0) begin
                    drain();
                end
                send(pick_sample());
                random_count++;
            end
            fresh = 1'b0;
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && averages_owed == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/wma_pkg.sv
rtl/wma_ram.sv
rtl/weighted_moving_average_filter.sv
verif/wma_average_checker.sv
verif/tb_weighted_moving_average_filter.sv
